// File: src/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Types, codes and constants shared by the path curve detector modules.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W     = 60;
	localparam int ITER_W       = 5;
	localparam int RANGE_W      = 17;
	localparam logic [RANGE_W-1:0] RANGE_MAX = 17'h1FFFF;

	localparam logic [14:0] RST_ENTER     = 15'd2048;
	localparam logic [14:0] RST_EXIT      = 15'd1024;
	localparam logic [4:0]  RST_STEPS     = 5'd4;
	localparam logic [15:0] RST_DEF_SPEED = 16'd1000;
	localparam logic [15:0] RST_MIN_SPEED = 16'd300;
	localparam logic [15:0] RST_DEF_FRONT = 16'd500;
	localparam logic [15:0] RST_DEF_REAR  = 16'd300;
	localparam logic [15:0] RST_MIN_RANGE = 16'd200;

	typedef enum logic [2:0] {
		CFG_ENTER, CFG_EXIT, CFG_STEPS, CFG_DEF_SPEED,
		CFG_MIN_SPEED, CFG_DEF_FRONT, CFG_DEF_REAR, CFG_MIN_RANGE
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TURN_STRAIGHT = 2'd0,
		TURN_RIGHT    = 2'd1,
		TURN_LEFT     = 2'd2
	} turn_t;

	typedef enum logic [1:0] {
		DIV_SPEED = 2'd0,
		DIV_FRONT = 2'd1,
		DIV_REAR  = 2'd2
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_C_INIT, ST_C_RUN, ST_C_END, ST_POST, ST_FLUSH,
		ST_FINISH, ST_M_INIT, ST_M_RUN, ST_M_END, ST_T_RUN, ST_MUL1, ST_MUL2,
		ST_MUL3, ST_D_INIT, ST_D_RUN, ST_D_END, ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic               last_point;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0]   raw_score;
		logic signed [15:0]   smoothed_score;
		logic [1:0]           turn_side;
		logic [15:0]          speed;
		logic [RANGE_W-1:0]   front_right_range;
		logic [RANGE_W-1:0]   front_left_range;
		logic [RANGE_W-1:0]   rear_right_range;
		logic [RANGE_W-1:0]   rear_left_range;
		logic                 last_result;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        hdg;
	} pt_t;

	typedef struct packed {
		logic load;
		logic point_put;
		logic cordic_init;
		logic cordic_step;
		logic score_store;
		logic flush_begin;
		logic finish;
		logic med_init;
		logic med_step;
		logic med_end;
		logic step_step;
		logic mul1;
		logic mul2;
		logic mul3;
		logic div_init;
		logic div_store;
		logic out_write;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic flushing;
		logic fin;
		logic flush_more;
		logic win_full;
		logic scnt_zero;
		logic cordic_last;
		logic med_last;
		logic step_last;
		logic div_last;
		logic div_sel_last;
		logic out_free;
	} stat_t;

	// atan(2^-i), 2^31 = pi
	function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: src/pcd_div.sv
// ----------------------------------------------------------------------------
// pcd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcd_div #(
	parameter int NW = 39,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic          last
);
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic          qbit;

	assign trial = {rem_q, num_q[NW-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign last  = busy_q && (cnt_q == CW'(NW-1));
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= qbit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], qbit};
		end
	end

endmodule

// File: src/pcd_ctrl.sv
// ----------------------------------------------------------------------------
// pcd_ctrl
// Sequencer: steps the datapath through load, scoring, median, step search,
// divisions and result write-back.
// ----------------------------------------------------------------------------
module pcd_ctrl import pcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_LOAD;
			ST_LOAD:   state_d = st.full ? ST_C_INIT : ST_POST;
			ST_C_INIT: state_d = ST_C_RUN;
			ST_C_RUN:  if (st.cordic_last) state_d = ST_C_END;
			ST_C_END:  state_d = ST_POST;
			ST_POST: begin
				if (!st.flushing) begin
					if (st.win_full)  state_d = ST_M_INIT;
					else if (st.fin)  state_d = ST_FLUSH;
					else              state_d = ST_IDLE;
				end else begin
					if (st.flush_more)     state_d = ST_C_INIT;
					else if (st.scnt_zero) state_d = ST_FINISH;
					else                   state_d = ST_M_INIT;
				end
			end
			ST_FLUSH:  state_d = ST_POST;
			ST_FINISH: state_d = ST_IDLE;
			ST_M_INIT: state_d = ST_M_RUN;
			ST_M_RUN:  if (st.med_last) state_d = ST_M_END;
			ST_M_END:  state_d = ST_T_RUN;
			ST_T_RUN:  if (st.step_last) state_d = ST_MUL1;
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_MUL3;
			ST_MUL3:   state_d = ST_D_INIT;
			ST_D_INIT: state_d = ST_D_RUN;
			ST_D_RUN:  if (st.div_last) state_d = ST_D_END;
			ST_D_END:  state_d = st.div_sel_last ? ST_OUT : ST_D_INIT;
			ST_OUT:    if (st.out_free) state_d = ST_POST;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		in_ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_LOAD:   cmd.point_put   = 1'b1;
			ST_C_INIT: cmd.cordic_init = 1'b1;
			ST_C_RUN:  cmd.cordic_step = 1'b1;
			ST_C_END:  cmd.score_store = 1'b1;
			ST_FLUSH:  cmd.flush_begin = 1'b1;
			ST_FINISH: cmd.finish      = 1'b1;
			ST_M_INIT: cmd.med_init    = 1'b1;
			ST_M_RUN:  cmd.med_step    = 1'b1;
			ST_M_END:  cmd.med_end     = 1'b1;
			ST_T_RUN:  cmd.step_step   = 1'b1;
			ST_MUL1:   cmd.mul1        = 1'b1;
			ST_MUL2:   cmd.mul2        = 1'b1;
			ST_MUL3:   cmd.mul3        = 1'b1;
			ST_D_INIT: cmd.div_init    = 1'b1;
			ST_D_END:  cmd.div_store   = 1'b1;
			ST_OUT:    cmd.out_write   = st.out_free;
			default: begin
			end
		endcase
	end

endmodule

// File: src/pcd_dpath.sv
// ----------------------------------------------------------------------------
// pcd_dpath
// Point and score stores, CORDIC vectoring unit, rank-count median, step
// search, products, shared divider and the result register.
// ----------------------------------------------------------------------------
module pcd_dpath import pcd_pkg::*; #(
	parameter int LOOKAHEAD = 16,
	parameter int WINDOW    = 8,
	parameter int MAX_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  in_item_t    in_data,
	input  cmd_t        cmd,
	output stat_t       st,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);
	localparam int PIW = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
	localparam int PCW = $clog2(LOOKAHEAD + 1);
	localparam int SD  = WINDOW + LOOKAHEAD;
	localparam int SIW = $clog2(SD);
	localparam int SCW = $clog2(SD + 1);
	localparam int CNW = $clog2(WINDOW + 1);
	localparam int SW  = $clog2(MAX_STEPS + 1);
	localparam int FW  = 16 + SW;
	localparam int RW  = 16 + FW;
	localparam int NW  = RW + 2;
	localparam int DW  = 17 + SW;
	localparam int LW  = 19 + SW;

	// configuration
	logic [14:0] enter_q, exit_q;
	logic [4:0]  steps_q;
	logic [15:0] dv_q, mv_q, df_q, dr_q, mr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q <= RST_ENTER;
			exit_q  <= RST_EXIT;
			steps_q <= RST_STEPS;
			dv_q    <= RST_DEF_SPEED;
			mv_q    <= RST_MIN_SPEED;
			df_q    <= RST_DEF_FRONT;
			dr_q    <= RST_DEF_REAR;
			mr_q    <= RST_MIN_RANGE;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENTER:     enter_q <= cfg_wdata[14:0];
				CFG_EXIT:      exit_q  <= cfg_wdata[14:0];
				CFG_STEPS:     steps_q <= cfg_wdata[4:0];
				CFG_DEF_SPEED: dv_q    <= cfg_wdata;
				CFG_MIN_SPEED: mv_q    <= cfg_wdata;
				CFG_DEF_FRONT: df_q    <= cfg_wdata;
				CFG_DEF_REAR:  dr_q    <= cfg_wdata;
				CFG_MIN_RANGE: mr_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// step count held inside [2, MAX_STEPS]
	logic [SW-1:0] s_sat;
	always_comb begin
		if (steps_q < 5'd2)
			s_sat = SW'(2);
		else if (32'(steps_q) > MAX_STEPS)
			s_sat = SW'(MAX_STEPS);
		else
			s_sat = SW'(steps_q);
	end

	// ---------------- control registers ----------------
	logic           fin_q, flushing_q;
	logic [PCW-1:0] pcnt_q, fj_q;
	logic [SCW-1:0] scnt_q;
	turn_t          prev_q;
	logic           out_valid_q;

	pt_t                pts_q [LOOKAHEAD];
	pt_t                in_q;
	logic signed [15:0] sc_q [SD];

	// ---------------- CORDIC ----------------
	logic signed [CORDIC_W-1:0] cx_q, cy_q;
	logic [31:0]                cz_q;
	logic [ITER_W-1:0]          it_q;
	logic [15:0]                chdg_q;
	logic                       czero_q;

	pt_t                        from_pt;
	logic signed [32:0]         dx, dy;
	logic signed [CORDIC_W-1:0] x0, y0, xs, ys;
	logic [31:0]                zr;
	logic [15:0]                d16;
	logic signed [16:0]         s_raw, s_fold;
	logic signed [15:0]         score;

	assign from_pt = pts_q[fj_q[PIW-1:0]];
	assign dx = $signed({in_q.x[31], in_q.x}) - $signed({from_pt.x[31], from_pt.x});
	assign dy = $signed({in_q.y[31], in_q.y}) - $signed({from_pt.y[31], from_pt.y});
	assign x0 = {{(CORDIC_W-57){dx[32]}}, dx, 24'd0};
	assign y0 = {{(CORDIC_W-57){dy[32]}}, dy, 24'd0};
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign zr = cz_q + 32'h0000_8000;
	assign d16 = zr[31:16] - chdg_q;

	always_comb begin
		s_raw = $signed({d16[15], d16});
		if (s_raw >= 17'sd16384)
			s_fold = s_raw - 17'sd32768;
		else if (s_raw < -17'sd16384)
			s_fold = s_raw + 17'sd32768;
		else
			s_fold = s_raw;
		// local x of zero lands on -pi/2 after the fold
		if (s_fold == -17'sd16384)
			s_fold = '0;
		score = czero_q ? 16'sd0 : s_fold[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			czero_q <= (dx == '0) && (dy == '0);
			chdg_q  <= from_pt.hdg;
			it_q    <= '0;
			if (dx < 0) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= 32'h8000_0000;
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			it_q <= it_q + 1'b1;
			if (cy_q >= 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_lut(it_q);
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_lut(it_q);
			end
		end
	end

	// ---------------- stores and counts ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q      <= 1'b0;
			flushing_q <= 1'b0;
			pcnt_q     <= '0;
			fj_q       <= '0;
			scnt_q     <= '0;
		end else begin
			if (cmd.load)
				fin_q <= in_data.last_point;
			if (cmd.point_put && (pcnt_q != PCW'(LOOKAHEAD)))
				pcnt_q <= pcnt_q + 1'b1;
			if (cmd.score_store) begin
				scnt_q <= scnt_q + 1'b1;
				if (flushing_q)
					fj_q <= fj_q + 1'b1;
			end
			if (cmd.out_write)
				scnt_q <= scnt_q - 1'b1;
			if (cmd.flush_begin) begin
				flushing_q <= 1'b1;
				fj_q       <= '0;
			end
			if (cmd.finish) begin
				flushing_q <= 1'b0;
				pcnt_q     <= '0;
				fj_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q.x   <= in_data.pos_x;
			in_q.y   <= in_data.pos_y;
			in_q.hdg <= in_data.heading;
		end
		if (cmd.point_put && (pcnt_q != PCW'(LOOKAHEAD)))
			pts_q[pcnt_q[PIW-1:0]] <= in_q;
		if (cmd.score_store && !flushing_q) begin
			for (int i = 0; i < LOOKAHEAD - 1; i++)
				pts_q[i] <= pts_q[i+1];
			pts_q[LOOKAHEAD-1] <= in_q;
		end
		if (cmd.score_store)
			sc_q[scnt_q[SIW-1:0]] <= score;
		if (cmd.out_write) begin
			for (int i = 0; i < SD - 1; i++)
				sc_q[i] <= sc_q[i+1];
		end
	end

	// ---------------- median by rank count ----------------
	logic [CNW-1:0]     mcnt_q, mk_q, mj_q, mlt_q, mle_q;
	logic               mph_q;
	logic signed [15:0] mvk_q, mlo_q, mhi_q;
	logic [CNW-1:0]     ridx, lt_n, le_n, m1, m0;
	logic signed [15:0] sc_rd;
	logic               jlast;

	assign ridx  = mph_q ? mj_q : mk_q;
	assign sc_rd = sc_q[SIW'(ridx)];
	assign lt_n  = mlt_q + CNW'(sc_rd < mvk_q);
	assign le_n  = mle_q + CNW'(sc_rd <= mvk_q);
	assign m1    = mcnt_q >> 1;
	assign m0    = m1 - 1'b1;
	assign jlast = (mj_q == mcnt_q - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.med_init) begin
			mcnt_q <= (scnt_q > SCW'(WINDOW)) ? CNW'(WINDOW) : CNW'(scnt_q);
			mk_q   <= '0;
			mph_q  <= 1'b0;
		end else if (cmd.med_step) begin
			if (!mph_q) begin
				mvk_q <= sc_rd;
				mj_q  <= '0;
				mlt_q <= '0;
				mle_q <= '0;
				mph_q <= 1'b1;
			end else if (jlast) begin
				// vk sits at sorted places lt..le-1
				if ((lt_n <= m1) && (m1 < le_n))
					mhi_q <= mvk_q;
				if ((lt_n <= m0) && (m0 < le_n))
					mlo_q <= mvk_q;
				mk_q  <= mk_q + 1'b1;
				mph_q <= 1'b0;
			end else begin
				mj_q  <= mj_q + 1'b1;
				mlt_q <= lt_n;
				mle_q <= le_n;
			end
		end
	end

	// ---------------- turn side and step search ----------------
	logic signed [15:0] raw_q, filt_q;
	turn_t              side_q;
	logic [SW-1:0]      idx_q, i_q;
	logic signed [LW-1:0] lhs_q, rhs_q;

	logic signed [16:0] msum, filt_n, filt17, en17, ex17, afilt, raw17, araw;
	logic signed [17:0] dif;
	turn_t              side_n;

	always_comb begin
		msum   = $signed({mhi_q[15], mhi_q}) + $signed({mlo_q[15], mlo_q});
		filt_n = mcnt_q[0] ? $signed({mhi_q[15], mhi_q}) : (msum >>> 1);
		filt17 = filt_n;
		en17   = $signed({2'b00, enter_q});
		ex17   = $signed({2'b00, exit_q});
		afilt  = (filt17 < 0) ? -filt17 : filt17;
		if (filt17 <= -en17)
			side_n = TURN_RIGHT;
		else if (filt17 >= en17)
			side_n = TURN_LEFT;
		else if ((prev_q != TURN_STRAIGHT) && (afilt >= ex17))
			side_n = prev_q;
		else
			side_n = TURN_STRAIGHT;
		raw17 = $signed({sc_q[0][15], sc_q[0]});
		araw  = (raw17 < 0) ? -raw17 : raw17;
		dif   = $signed({araw[16], araw}) - $signed({3'b000, enter_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= TURN_STRAIGHT;
		end else if (cmd.med_end) begin
			prev_q <= side_n;
		end else if (cmd.finish) begin
			prev_q <= TURN_STRAIGHT;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.med_end) begin
			raw_q  <= sc_q[0];
			filt_q <= filt_n[15:0];
			side_q <= side_n;
			lhs_q  <= LW'(dif) * LW'($signed({1'b0, s_sat - 1'b1}));
			rhs_q  <= '0;
			idx_q  <= '0;
			i_q    <= SW'(1);
		end else if (cmd.step_step) begin
			if (lhs_q > rhs_q)
				idx_q <= idx_q + 1'b1;
			rhs_q <= rhs_q + $signed(LW'(enter_q));
			i_q   <= i_q + 1'b1;
		end
	end

	// ---------------- products ----------------
	logic [FW-1:0] pva_q, pvb_q, pfa_q, pfb_q, dfs_q, vnum_q, fnum_q;
	logic [RW-1:0] rnum_q;

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			pva_q <= FW'(dv_q) * FW'(s_sat - idx_q);
			pvb_q <= FW'(mv_q) * FW'(idx_q);
			pfa_q <= FW'(df_q) * FW'(s_sat - idx_q);
			pfb_q <= FW'(mr_q) * FW'(idx_q);
			dfs_q <= FW'(df_q) * FW'(s_sat);
		end
		if (cmd.mul2) begin
			vnum_q <= pva_q + pvb_q;
			fnum_q <= pfa_q + pfb_q;
		end
		if (cmd.mul3)
			rnum_q <= RW'(dr_q) * RW'(fnum_q);
	end

	// ---------------- rounded divisions ----------------
	div_sel_t      dsel_q;
	logic [RW-1:0] div_a;
	logic [FW-1:0] div_d;
	logic [NW-1:0] div_n, quo;
	logic          div_last;
	logic [15:0]   spd_q;
	logic [RANGE_W-1:0] sf_q, sr_q;

	always_comb begin
		case (dsel_q)
			DIV_SPEED: begin
				div_a = RW'(vnum_q);
				div_d = FW'(s_sat);
			end
			DIV_FRONT: begin
				div_a = RW'(fnum_q);
				div_d = FW'(s_sat);
			end
			default: begin
				div_a = rnum_q;
				div_d = dfs_q;
			end
		endcase
		// floor((2a + d) / 2d)
		div_n = (NW'(div_a) << 1) + NW'(div_d);
	end

	pcd_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_init),
		.num    (div_n),
		.den    (DW'(div_d) << 1),
		.quo    (quo),
		.last   (div_last)
	);

	always_ff @(posedge clk) begin
		if (cmd.med_init)
			dsel_q <= DIV_SPEED;
		if (cmd.div_store) begin
			case (dsel_q)
				DIV_SPEED: begin
					spd_q  <= quo[15:0];
					dsel_q <= DIV_FRONT;
				end
				DIV_FRONT: begin
					sf_q   <= quo[RANGE_W-1:0];
					dsel_q <= DIV_REAR;
				end
				default: begin
					sr_q <= (quo > NW'(RANGE_MAX)) ? RANGE_MAX : quo[RANGE_W-1:0];
				end
			endcase
		end
	end

	// ---------------- result word ----------------
	logic [RANGE_W-1:0] two_f, two_r, sf, lf, sr, lr;
	logic [15:0]        spd;
	out_item_t          res, out_q;

	always_comb begin
		two_f = {df_q, 1'b0};
		two_r = {dr_q, 1'b0};
		sf = RANGE_W'(df_q);
		lf = RANGE_W'(df_q);
		sr = RANGE_W'(dr_q);
		lr = RANGE_W'(dr_q);
		spd = dv_q;
		if (side_q != TURN_STRAIGHT) begin
			spd = spd_q;
			if (df_q != '0) begin
				sf = sf_q;
				sr = sr_q;
				lf = (sf_q > two_f) ? '0 : two_f - sf_q;
				lr = (sr_q > two_r) ? '0 : two_r - sr_q;
			end
		end
		res.raw_score      = raw_q;
		res.smoothed_score = filt_q;
		res.turn_side      = side_q;
		res.speed          = spd;
		// right turn: long ranges on the right side
		if (side_q == TURN_RIGHT) begin
			res.front_right_range = lf;
			res.front_left_range  = sf;
			res.rear_right_range  = lr;
			res.rear_left_range   = sr;
		end else begin
			res.front_right_range = sf;
			res.front_left_range  = lf;
			res.rear_right_range  = sr;
			res.rear_left_range   = lr;
		end
		res.last_result = flushing_q && (scnt_q == SCW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_write) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_write)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- status ----------------
	always_comb begin
		st.full         = (pcnt_q == PCW'(LOOKAHEAD));
		st.flushing     = flushing_q;
		st.fin          = fin_q;
		st.flush_more   = (fj_q < pcnt_q);
		st.win_full     = (scnt_q == SCW'(WINDOW));
		st.scnt_zero    = (scnt_q == '0);
		st.cordic_last  = (it_q == ITER_W'(CORDIC_STEPS - 1));
		st.med_last     = mph_q && jlast && (mk_q == mcnt_q - 1'b1);
		st.step_last    = (i_q == s_sat);
		st.div_last     = div_last;
		st.div_sel_last = (dsel_q == DIV_REAR);
		st.out_free     = !out_valid_q || out_ready;
	end

endmodule

// File: src/path_curve_detector_top.sv
// ----------------------------------------------------------------------------
// path_curve_detector_top
// Path curve detector: bend score, forward median, turn side, speed/ranges.
// ----------------------------------------------------------------------------
// A point's result word leaves LOOKAHEAD+WINDOW-1 points after it enters; the
// final point flushes every pending word. Points are handled one at a time.
// A point that yields nothing is only stored; one that only scores also runs
// the 24-step CORDIC. Each result word adds the rank count median over n
// scores, the step search over the clamped step count, the products, three
// restoring divisions on the shared divider and the write-back, which waits
// while the previous result word has not been taken.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module path_curve_detector_top import pcd_pkg::*; #(
	parameter int LOOKAHEAD = 16,
	parameter int WINDOW    = 8,
	parameter int MAX_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);
	cmd_t  cmd;
	stat_t st;

	pcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	pcd_dpath #(
		.LOOKAHEAD (LOOKAHEAD),
		.WINDOW    (WINDOW),
		.MAX_STEPS (MAX_STEPS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a point is in progress");

	a_write_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_write |-> (!out_valid || out_ready))
		else $error("result word overwritten before it was taken");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.cordic_step, cmd.med_step, cmd.step_step, cmd.out_write}))
		else $error("two sequenced units active at once");
`endif

endmodule

// File: tb/tb_path_curve_detector_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_path_curve_detector_top
// Drives whole paths (smooth bends, straight runs, corner cases and random
// noise) through the curve detector under several register settings, models
// the bend score, median, turn side and speed/range steps, and checks every
// result word in order against the model.
// ----------------------------------------------------------------------------
module tb_path_curve_detector_top;
	import pcd_pkg::*;

	localparam int LOOKAHEAD   = 16;
	localparam int WINDOW      = 8;
	localparam int MAX_STEPS   = 16;
	localparam int DRAIN_WAIT  = 400;
	localparam int STALL_LIMIT = 300000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;

	path_curve_detector_top #(
		.LOOKAHEAD(LOOKAHEAD), .WINDOW(WINDOW), .MAX_STEPS(MAX_STEPS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor copy of the registers and state
	logic [14:0] enter_thr, exit_thr;
	logic [4:0]  n_steps;
	logic [15:0] def_speed, min_speed, def_front, def_rear, min_range;
	pt_t         pts [0:LOOKAHEAD];
	int          scores [0:WINDOW-1];
	turn_t       last_side;
	int          seen;

	out_item_t   pending_words[$];
	int          errors;
	bit          tx_calm, rx_calm;

	const logic [31:0] ATAN [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int bend_angle(pt_t a, pt_t b);
		longint x, y, xs, ys;
		logic [31:0] z;
		logic [15:0] a16, d;
		int s;
		x = (longint'(b.x) - longint'(a.x)) * 64'sd16777216;
		y = (longint'(b.y) - longint'(a.y)) * 64'sd16777216;
		if (x == 0 && y == 0)
			return 0;
		z = 32'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += ATAN[i];
			end else begin
				x -= ys; y += xs; z -= ATAN[i];
			end
		end
		a16 = 16'((z + 32'h8000) >> 16);
		d = a16 - a.hdg;
		s = int'($signed(d));
		if (s >= 16384) s -= 32768;
		else if (s < -16384) s += 32768;
		// local x zero folds to -pi/2: scored straight
		if (s == -16384) s = 0;
		return s;
	endfunction

	function automatic int median_score(int v[0:23], int off, int n);
		int t[0:23];
		int k, j;
		for (int i = 0; i < n; i++) begin
			k = v[off + i];
			j = i;
			while (j > 0 && t[j-1] > k) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = k;
		end
		if (n % 2)
			return t[n/2];
		return (t[n/2] + t[n/2-1]) >>> 1;
	endfunction

	function automatic longint round_div(longint a, longint d);
		return (2*a + d) / (2*d);
	endfunction

	task automatic add_word(int raw, int filt, bit fin);
		out_item_t w;
		turn_t side;
		longint s, idx, spd, sf, lf, sr, lr, fnum, en, af, ar;
		side = TURN_STRAIGHT;
		en = enter_thr;
		af = filt < 0 ? -filt : filt;
		ar = raw < 0 ? -raw : raw;
		if (filt <= -en) side = TURN_RIGHT;
		else if (filt >= en) side = TURN_LEFT;
		else if (last_side != TURN_STRAIGHT && af >= exit_thr) side = last_side;
		last_side = side;
		spd = def_speed;
		sf = def_front; lf = def_front;
		sr = def_rear;  lr = def_rear;
		if (side != TURN_STRAIGHT) begin
			s = n_steps < 2 ? 2 : (n_steps > MAX_STEPS ? MAX_STEPS : n_steps);
			idx = 0;
			for (longint i = 1; i <= s; i++)
				if ((ar - en) * (s - 1) > en * (i - 1))
					idx++;
			spd = round_div(longint'(def_speed) * (s - idx) + longint'(min_speed) * idx, s);
			if (def_front != 0) begin
				fnum = longint'(def_front) * (s - idx) + longint'(min_range) * idx;
				sf = round_div(fnum, s);
				sr = round_div(longint'(def_rear) * fnum, longint'(def_front) * s);
				if (sr > RANGE_MAX) sr = RANGE_MAX;
				lf = sf > 2*longint'(def_front) ? 0 : 2*longint'(def_front) - sf;
				lr = sr > 2*longint'(def_rear) ? 0 : 2*longint'(def_rear) - sr;
			end
		end
		w.raw_score         = 16'(raw);
		w.smoothed_score    = 16'(filt);
		w.turn_side         = side;
		w.speed             = 16'(spd);
		w.front_right_range = RANGE_W'(side == TURN_RIGHT ? lf : sf);
		w.front_left_range  = RANGE_W'(side == TURN_RIGHT ? sf : lf);
		w.rear_right_range  = RANGE_W'(side == TURN_RIGHT ? lr : sr);
		w.rear_left_range   = RANGE_W'(side == TURN_RIGHT ? sr : lr);
		w.last_result       = fin;
		pending_words = {pending_words, w};
	endtask

	task automatic predict_point(in_item_t it);
		int pc, sc, tot, sc_score;
		int tmp[0:23];
		pc = seen < LOOKAHEAD ? seen : LOOKAHEAD;
		sc = seen > LOOKAHEAD ? seen - LOOKAHEAD : 0;
		if (sc > WINDOW - 1) sc = WINDOW - 1;
		pts[pc] = '{x: it.pos_x, y: it.pos_y, hdg: it.heading};
		pc++;
		if (seen < LOOKAHEAD + WINDOW) seen++;
		if (pc == LOOKAHEAD + 1) begin
			sc_score = bend_angle(pts[0], pts[LOOKAHEAD]);
			for (int i = 0; i < LOOKAHEAD; i++) pts[i] = pts[i+1];
			pc = LOOKAHEAD;
			scores[sc] = sc_score;
			sc++;
			if (sc == WINDOW) begin
				for (int i = 0; i < WINDOW; i++) tmp[i] = scores[i];
				add_word(scores[0], median_score(tmp, 0, WINDOW), 1'b0);
				for (int i = 0; i < WINDOW - 1; i++) scores[i] = scores[i+1];
				sc = WINDOW - 1;
			end
		end
		if (it.last_point) begin
			// flush: window and lookahead cut at the path end
			tot = 0;
			for (int j = 0; j < sc; j++) tmp[tot++] = scores[j];
			for (int j = 0; j < pc; j++) tmp[tot++] = bend_angle(pts[j], pts[pc-1]);
			for (int j = 0; j < tot; j++)
				add_word(tmp[j], median_score(tmp, j, tot - j < WINDOW ? tot - j : WINDOW),
					j + 1 == tot);
			seen = 0;
			last_side = TURN_STRAIGHT;
		end
	endtask

	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// entered just after a rising edge, returns just after the accepting edge
	task automatic send_point(in_item_t it);
		int gap;
		bit took;
		gap = pick_gap(tx_calm);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		predict_point(it);
	endtask

	task automatic drain;
		// nothing new may be offered while the block works through the path end
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_ENTER:     enter_thr = v[14:0];
			CFG_EXIT:      exit_thr  = v[14:0];
			CFG_STEPS:     n_steps   = v[4:0];
			CFG_DEF_SPEED: def_speed = v;
			CFG_MIN_SPEED: min_speed = v;
			CFG_DEF_FRONT: def_front = v;
			CFG_DEF_REAR:  def_rear  = v;
			CFG_MIN_RANGE: min_range = v;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] en, logic [15:0] ex, logic [15:0] st,
			logic [15:0] dv, logic [15:0] mv, logic [15:0] df, logic [15:0] dr,
			logic [15:0] mr);
		write_reg(CFG_ENTER, en);
		write_reg(CFG_EXIT, ex);
		write_reg(CFG_STEPS, st);
		write_reg(CFG_DEF_SPEED, dv);
		write_reg(CFG_MIN_SPEED, mv);
		write_reg(CFG_DEF_FRONT, df);
		write_reg(CFG_DEF_REAR, dr);
		write_reg(CFG_MIN_RANGE, mr);
	endtask

	function automatic in_item_t mk_point(longint x, longint y, int hdg, bit fin);
		in_item_t it;
		it.pos_x      = 32'(x);
		it.pos_y      = 32'(y);
		it.heading    = 16'(hdg);
		it.last_point = fin;
		return it;
	endfunction

	function automatic in_item_t noise_point(bit fin);
		in_item_t it;
		it.pos_x      = $urandom;
		it.pos_y      = $urandom;
		it.heading    = 16'($urandom);
		it.last_point = fin;
		return it;
	endfunction

	// smooth path with random bends; with noisy set, a few points turn to noise
	task automatic send_path(int len, bit noisy);
		real px, py, th, bend, seg;
		int hdg;
		px = real'($urandom_range(200000)) - 100000.0;
		py = real'($urandom_range(200000)) - 100000.0;
		th = real'($urandom_range(6283)) / 1000.0 - 3.1416;
		bend = 0.0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(5) == 0)
				bend = (real'($urandom_range(600)) - 300.0) / 1000.0;
			seg = real'($urandom_range(30, 400));
			hdg = int'(th / 3.14159265358979 * 32768.0);
			if ($urandom_range(11) == 0) hdg = $urandom;
			if (noisy && $urandom_range(9) == 0)
				send_point(noise_point(i == len - 1));
			else
				send_point(mk_point(longint'(px), longint'(py), hdg, i == len - 1));
			px += seg * $cos(th);
			py += seg * $sin(th);
			th += bend;
		end
	endtask

	task automatic test_directed;
		// single point path and a zero offset
		send_point(mk_point(0, 0, 0, 1'b1));
		send_point(mk_point(5, 5, 100, 1'b0));
		send_point(mk_point(5, 5, 100, 1'b1));
		// offset pointing backwards, heading extremes
		send_point(mk_point(1000, 0, -32768, 1'b0));
		send_point(mk_point(-2000, 300, 32767, 1'b1));
		// local x zero: straight up with heading 0, along x with heading pi/2
		send_point(mk_point(0, 0, 0, 1'b0));
		send_point(mk_point(0, 700, 0, 1'b1));
		send_point(mk_point(0, 0, 16384, 1'b0));
		send_point(mk_point(700, 0, 16384, 1'b1));
		// coordinate extremes
		send_point(mk_point(32'sh7FFF_FFFF, -32'sh8000_0000, 0, 1'b0));
		send_point(mk_point(-32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b0));
		send_point(mk_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1, 1'b1));
		drain();
		// one path long enough to emit before its end
		send_path(LOOKAHEAD + WINDOW + 2, 1'b0);
		drain();
	endtask

	task automatic test_default_regs;
		repeat (2) send_path($urandom_range(5, 40), 1'b1);
		// sender holds off until everything is out
		drain();
		send_path($urandom_range(20, 40), 1'b0);
		drain();
	endtask

	task automatic test_low_extremes;
		// zero thresholds, step count below range, zero defaults
		set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_path($urandom_range(10, 30), 1'b1);
		drain();
		set_regs(16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
		send_path($urandom_range(10, 30), 1'b1);
		drain();
	endtask

	task automatic test_high_extremes;
		set_regs(16'd16384, 16'd16384, 16'd16, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
		send_path($urandom_range(10, 30), 1'b1);
		drain();
		set_regs(16'hFFFF, 16'hFFFF, 16'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
		send_path($urandom_range(10, 30), 1'b1);
		drain();
		// low thresholds, many steps, tiny front range against a big rear one
		set_regs(16'd200, 16'd50, 16'd16, 16'd5000, 16'd10, 16'd3, 16'hFFFF, 16'd40000);
		send_path($urandom_range(10, 30), 1'b1);
		drain();
	endtask

	task automatic test_random_regs;
		for (int k = 0; k < 6; k++) begin
			set_regs(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 3000)),
				16'($urandom_range(0, 31)), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
			tx_calm = (k == 2);
			rx_calm = (k == 3);
			send_path($urandom_range(3, 40), 1'b1);
			if (k == 4)
				repeat (15) send_point(noise_point($urandom_range(7) == 0));
			send_point(noise_point(1'b1));
			drain();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// result receiver stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_calm || $urandom_range(99) < 60) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(99) < 90) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	// check each result word; signals are stable at the falling edge
	always @(negedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: result word with none expected: %p", $realtime, out_data);
				errors++;
			end else begin
				w = pending_words.pop_front();
				if (out_data !== w) begin
					$display("%0t: mismatch expected %p", $realtime, w);
					$display("%0t:          actual   %p", $realtime, out_data);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				idle = 0;
			else
				idle++;
			if (idle >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		errors    = 0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ENTER;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		enter_thr = RST_ENTER;
		exit_thr  = RST_EXIT;
		n_steps   = RST_STEPS;
		def_speed = RST_DEF_SPEED;
		min_speed = RST_MIN_SPEED;
		def_front = RST_DEF_FRONT;
		def_rear  = RST_DEF_REAR;
		min_range = RST_MIN_RANGE;
		last_side = TURN_STRAIGHT;
		seen      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (DRAIN_WAIT) @(posedge clk);

		test_directed();
		test_default_regs();
		test_low_extremes();
		test_high_extremes();
		test_random_regs();

		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
